>>> hdl/ar3d_pkg.sv
// ar3d_pkg: shared widths, item types, axis codes and the CORDIC arctangent
// table for the axis rotation block. No dependencies.
package ar3d_pkg;

  // Field widths (Q8.8 coordinates, binary angle)
  localparam int COORD_WIDTH = 16;
  localparam int ANGLE_WIDTH = 16;

  // CORDIC datapath
  localparam int GUARD_BITS      = 12;
  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int DATA_WIDTH      = COORD_WIDTH + GUARD_BITS + 4;  // a/b with CORDIC growth
  localparam int RESID_WIDTH     = 32;                            // angle in 2^-32 turns

  // Gain compensation: (v * INV_GAIN + 2^(RND_SHIFT-1)) >>> RND_SHIFT
  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
  localparam int PROD_WIDTH = DATA_WIDTH + 33;
  localparam int RND_SHIFT  = 32 + GUARD_BITS;

  // Axis selector codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DATA_WIDTH-1:0]  data_t;
  typedef logic signed [RESID_WIDTH-1:0] resid_t;

  typedef struct packed {
    logic [1:0]             mode;
    coord_t                 in_x;
    coord_t                 in_y;
    coord_t                 in_z;
    logic [ANGLE_WIDTH-1:0] turn_angle;
  } pnt_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
  } rot_t;

  // One item in flight through the CORDIC stages
  typedef struct packed {
    data_t      a;
    data_t      b;
    resid_t     resid;
    logic [1:0] mode;
    coord_t     x;
    coord_t     y;
    coord_t     z;
  } cord_t;

  // round(atan(2^-i) / (2 pi) * 2^32)
  function automatic resid_t atan_turn(input int idx);
    resid_t r;
    unique case (idx)
      0:       r = 32'h2000_0000;
      1:       r = 32'h12E4_051E;
      2:       r = 32'h09FB_385B;
      3:       r = 32'h0511_11D4;
      4:       r = 32'h028B_0D43;
      5:       r = 32'h0145_D7E1;
      6:       r = 32'h00A2_F61E;
      7:       r = 32'h0051_7C55;
      8:       r = 32'h0028_BE53;
      9:       r = 32'h0014_5F2F;
      10:      r = 32'h000A_2F98;
      11:      r = 32'h0005_17CC;
      12:      r = 32'h0002_8BE6;
      13:      r = 32'h0001_45F3;
      14:      r = 32'h0000_A2FA;
      15:      r = 32'h0000_517D;
      16:      r = 32'h0000_28BE;
      17:      r = 32'h0000_145F;
      18:      r = 32'h0000_0A30;
      19:      r = 32'h0000_0518;
      20:      r = 32'h0000_028C;
      21:      r = 32'h0000_0146;
      22:      r = 32'h0000_00A3;
      23:      r = 32'h0000_0051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/ar3d_cordic_stage.sv
// ar3d_cordic_stage: one pipeline register stage holding STEPS_PER_STAGE
// CORDIC micro-rotations. Depends on ar3d_pkg.
module ar3d_cordic_stage #(
  parameter int STEP_BASE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           up_vld,
  input  ar3d_pkg::cord_t up,
  output logic           dn_vld,
  output ar3d_pkg::cord_t dn
);
  import ar3d_pkg::*;

  cord_t dn_next;

  always_comb begin
    data_t  a;
    data_t  b;
    data_t  da;
    data_t  db;
    resid_t r;
    a = up.a;
    b = up.b;
    r = up.resid;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      da = b >>> (STEP_BASE + k);
      db = a >>> (STEP_BASE + k);
      if (!r[RESID_WIDTH-1]) begin
        a = a - da;
        b = b + db;
        r = r - atan_turn(STEP_BASE + k);
      end else begin
        a = a + da;
        b = b - db;
        r = r + atan_turn(STEP_BASE + k);
      end
    end
    dn_next       = up;
    dn_next.a     = a;
    dn_next.b     = b;
    dn_next.resid = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_vld <= 1'b0;
    end else if (en) begin
      dn_vld <= up_vld;
    end
    if (en) begin
      dn <= dn_next;
    end
  end

endmodule

>>> hdl/ar3d_gain.sv
// ar3d_gain: CORDIC gain compensation (multiply stage, then round/saturate
// and output assembly stage). Depends on ar3d_pkg.
module ar3d_gain (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           up_vld,
  input  ar3d_pkg::cord_t up,
  output logic           dn_vld,
  output ar3d_pkg::rot_t  dn
);
  import ar3d_pkg::*;

  localparam int QW = PROD_WIDTH - RND_SHIFT;

  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  function automatic coord_t round_sat(input prod_t p);
    prod_t          r;
    logic [QW-1:0]  q;
    coord_t         s;
    r = p + $signed({{(PROD_WIDTH-RND_SHIFT){1'b0}}, 1'b1, {(RND_SHIFT-1){1'b0}}});
    q = r[PROD_WIDTH-1:RND_SHIFT];
    if ((&q[QW-1:COORD_WIDTH-1]) || !(|q[QW-1:COORD_WIDTH-1])) begin
      s = q[COORD_WIDTH-1:0];
    end else if (q[QW-1]) begin
      s = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      s = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return s;
  endfunction

  // multiply stage
  prod_t      prod_a;
  prod_t      prod_b;
  logic [1:0] mode;
  coord_t     x;
  coord_t     y;
  coord_t     z;
  logic       prod_vld;

  rot_t dn_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      dn_vld   <= 1'b0;
    end else if (en) begin
      prod_vld <= up_vld;
      dn_vld   <= prod_vld;
    end
    if (en) begin
      prod_a <= up.a * $signed({1'b0, INV_GAIN});
      prod_b <= up.b * $signed({1'b0, INV_GAIN});
      mode   <= up.mode;
      x      <= up.x;
      y      <= up.y;
      z      <= up.z;
      dn     <= dn_next;
    end
  end

  always_comb begin
    coord_t sa;
    coord_t sb;
    sa = round_sat(prod_a);
    sb = round_sat(prod_b);
    dn_next.out_x = x;
    dn_next.out_y = y;
    dn_next.out_z = z;
    unique case (mode)
      AXIS_X: begin
        dn_next.out_y = sa;
        dn_next.out_z = sb;
      end
      AXIS_Y: begin
        dn_next.out_z = sa;
        dn_next.out_x = sb;
      end
      AXIS_Z: begin
        dn_next.out_x = sa;
        dn_next.out_y = sb;
      end
      AXIS_NONE: begin
      end
    endcase
  end

endmodule

>>> hdl/axis_rotation_3d.sv
// axis_rotation_3d: top level, rotates a Q8.8 point about the X, Y or Z axis.
// Depends on ar3d_pkg, ar3d_cordic_stage and ar3d_gain.
//
//   channel   dir   handshake               payload
//   pnt       in    pnt_valid / pnt_stall   pnt_t {mode, in_x, in_y, in_z, turn_angle}
//   rot       out   rot_valid / rot_stall   rot_t {out_x, out_y, out_z}
//
// Throughput: one item per clock while rot is not stalled. Pipeline: 1 quadrant/setup
// stage, 12 CORDIC stages of 2 micro-rotations each, 2 gain/saturation stages.
// Reset (rst, synchronous) clears only the valid bits; data registers are not reset.
// Stall: the whole pipeline freezes while a result sits on rot with rot_stall
// high; pnt_stall is raised in that same cycle, so nothing is dropped or repeated.
// Bubbles keep moving whenever the output is empty or being taken.
module axis_rotation_3d (
  input  logic          clk,
  input  logic          rst,
  input  logic          pnt_valid,
  output logic          pnt_stall,
  input  ar3d_pkg::pnt_t pnt,
  output logic          rot_valid,
  input  logic          rot_stall,
  output ar3d_pkg::rot_t rot
);
  import ar3d_pkg::*;

  // Global advance: everything shifts unless the output holds an untaken item.
  logic en;
  assign en        = !(rot_valid && rot_stall);
  assign pnt_stall = !en;

  // ---------------------------------------------------------------------------
  // Setup stage: pick the rotated pair, scale by 2^GUARD_BITS, apply the
  // quadrant as exact 90 degree turns, keep the low 14 angle bits as residual.
  // ---------------------------------------------------------------------------
  cord_t setup_next;
  cord_t setup;
  logic  setup_vld;

  always_comb begin
    logic [31:0] t;
    data_t       ea;
    data_t       eb;
    coord_t      pa;
    coord_t      pb;
    t = {pnt.turn_angle, {(32-ANGLE_WIDTH){1'b0}}};
    unique case (pnt.mode)
      AXIS_X: begin
        pa = pnt.in_y;
        pb = pnt.in_z;
      end
      AXIS_Y: begin
        pa = pnt.in_z;
        pb = pnt.in_x;
      end
      AXIS_Z: begin
        pa = pnt.in_x;
        pb = pnt.in_y;
      end
      AXIS_NONE: begin
        pa = pnt.in_x;
        pb = pnt.in_y;
      end
    endcase
    ea = {{(DATA_WIDTH-COORD_WIDTH-GUARD_BITS){pa[COORD_WIDTH-1]}}, pa, {GUARD_BITS{1'b0}}};
    eb = {{(DATA_WIDTH-COORD_WIDTH-GUARD_BITS){pb[COORD_WIDTH-1]}}, pb, {GUARD_BITS{1'b0}}};
    unique case (t[31:30])
      2'd0: begin
        setup_next.a = ea;
        setup_next.b = eb;
      end
      2'd1: begin
        setup_next.a = -eb;
        setup_next.b = ea;
      end
      2'd2: begin
        setup_next.a = -ea;
        setup_next.b = -eb;
      end
      2'd3: begin
        setup_next.a = eb;
        setup_next.b = -ea;
      end
    endcase
    setup_next.resid = {2'b00, t[29:0]};
    setup_next.mode  = pnt.mode;
    setup_next.x     = pnt.in_x;
    setup_next.y     = pnt.in_y;
    setup_next.z     = pnt.in_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_vld <= 1'b0;
    end else if (en) begin
      setup_vld <= pnt_valid;
    end
    if (en) begin
      setup <= setup_next;
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC chain: stage s performs micro-rotations s*2 and s*2+1.
  // ---------------------------------------------------------------------------
  cord_t chain     [CORDIC_STAGES+1];
  logic  chain_vld [CORDIC_STAGES+1];

  assign chain[0]     = setup;
  assign chain_vld[0] = setup_vld;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    ar3d_cordic_stage #(
      .STEP_BASE(s * STEPS_PER_STAGE)
    ) u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .up_vld(chain_vld[s]),
      .up    (chain[s]),
      .dn_vld(chain_vld[s+1]),
      .dn    (chain[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Gain compensation, rounding, saturation; its last register drives rot.
  // ---------------------------------------------------------------------------
  ar3d_gain u_gain (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .up_vld(chain_vld[CORDIC_STAGES]),
    .up    (chain[CORDIC_STAGES]),
    .dn_vld(rot_valid),
    .dn    (rot)
  );

endmodule

>>> test/ar3d_checker.sv
// ar3d_checker: watches the pnt and rot channels of axis_rotation_3d, predicts each
// rotated point and compares it with what the block returns, in order.
// Depends on ar3d_pkg for the item types and axis codes.
module ar3d_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           pnt_valid,
  input  logic           pnt_stall,
  input  ar3d_pkg::pnt_t pnt,
  input  logic           rot_valid,
  input  logic           rot_stall,
  input  ar3d_pkg::rot_t rot,
  output int             error_count,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ar3d_pkg::*;

  localparam int FRAC_GUARD = 12;
  localparam int MICRO_ROTS = 24;
  localparam int MAX_PRINTS = 100;

  // atan(2^-i) in 2^-32 turn units
  longint arctan_turns [MICRO_ROTS] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
    64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
    64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051
  };

  typedef struct {
    pnt_t src;
    rot_t want;
  } point_check_t;

  point_check_t expected_rots[$];

  // Undo CORDIC gain (x 0x9B74EDA8 / 2^32), round half up, drop guard bits, saturate.
  function automatic longint scale_back(longint v);
    longint acc;
    longint hi;
    hi  = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    acc = v * 64'sh9B74 + ((v * 64'shEDA8) >>> 16);
    acc = (acc + (64'sd1 <<< (15 + FRAC_GUARD))) >>> (16 + FRAC_GUARD);
    if (acc > hi) acc = hi;
    else if (acc < -hi - 1) acc = -hi - 1;
    return acc;
  endfunction

  function automatic rot_t predict_rotation(pnt_t p);
    longint u, v, du, dv, resid, tmp;
    logic [31:0] turns;
    rot_t r;
    r.out_x = p.in_x;
    r.out_y = p.in_y;
    r.out_z = p.in_z;
    if (p.mode == AXIS_NONE) return r;
    // (u, v) is the plane pair, rotated as u' = u c - v s, v' = u s + v c
    case (p.mode)
      AXIS_X:  begin u = $signed(p.in_y); v = $signed(p.in_z); end
      AXIS_Y:  begin u = $signed(p.in_z); v = $signed(p.in_x); end
      default: begin u = $signed(p.in_x); v = $signed(p.in_y); end
    endcase
    u = u * (64'sd1 <<< FRAC_GUARD);
    v = v * (64'sd1 <<< FRAC_GUARD);
    turns = 32'(p.turn_angle) << (32 - ANGLE_WIDTH);
    // whole quarter turns first, exactly
    repeat (turns[31:30]) begin
      tmp = -v;
      v   = u;
      u   = tmp;
    end
    resid = longint'(turns[29:0]);
    for (int i = 0; i < MICRO_ROTS; i++) begin
      du = v >>> i;
      dv = u >>> i;
      if (resid >= 0) begin
        u     = u - du;
        v     = v + dv;
        resid = resid - arctan_turns[i];
      end else begin
        u     = u + du;
        v     = v - dv;
        resid = resid + arctan_turns[i];
      end
    end
    u = scale_back(u);
    v = scale_back(v);
    case (p.mode)
      AXIS_X:  begin r.out_y = coord_t'(u); r.out_z = coord_t'(v); end
      AXIS_Y:  begin r.out_z = coord_t'(u); r.out_x = coord_t'(v); end
      default: begin r.out_x = coord_t'(u); r.out_y = coord_t'(v); end
    endcase
    return r;
  endfunction

  task automatic report_error(string msg);
    if (error_count < MAX_PRINTS) $display("%0t ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, coord_t got, coord_t want, pnt_t src);
    if (got !== want)
      report_error($sformatf("%s got %0d want %0d (mode %0d pt %0d,%0d,%0d angle 0x%04h)",
                             name, got, want, src.mode, src.in_x, src.in_y, src.in_z,
                             src.turn_angle));
  endtask

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    point_check_t rec;
    if (!rst) begin
      if (rot_valid && !rot_stall) begin
        if (expected_rots.size() == 0) begin
          report_error($sformatf("result with nothing pending: %0d,%0d,%0d",
                                 rot.out_x, rot.out_y, rot.out_z));
        end else begin
          rec = expected_rots.pop_front();
          check_field("out_x", rot.out_x, rec.want.out_x, rec.src);
          check_field("out_y", rot.out_y, rec.want.out_y, rec.src);
          check_field("out_z", rot.out_z, rec.want.out_z, rec.src);
        end
      end
      if (pnt_valid && !pnt_stall) begin
        rec.src  = pnt;
        rec.want = predict_rotation(pnt);
        expected_rots.push_back(rec);
      end
      outstanding = expected_rots.size();
    end
  end

endmodule

>>> test/tb_axis_rotation_3d.sv
// tb_axis_rotation_3d: drives points into axis_rotation_3d under random gaps and
// back-pressure and gives the verdict; checking lives in ar3d_checker.
// Depends on ar3d_pkg, axis_rotation_3d and ar3d_checker.
module tb_axis_rotation_3d;
  timeunit 1ns;
  timeprecision 1ps;

  import ar3d_pkg::*;

  localparam int RANDOM_POINTS = 1500;
  localparam int HOLD_CYCLES   = 200;      // long receiver hold-off
  localparam int DRAIN_CYCLES  = 40;       // leave margin after the last result
  localparam int CYCLE_LIMIT   = 1000000;

  logic clk;
  logic rst;
  logic pnt_valid;
  logic pnt_stall;
  pnt_t pnt;
  logic rot_valid;
  logic rot_stall;
  rot_t rot;

  int   error_count;
  int   outstanding;
  int   cycles;
  bit   hold_req;   // set by the sender side, picked up by the receiver process

  axis_rotation_3d u_top (
    .clk       (clk),
    .rst       (rst),
    .pnt_valid (pnt_valid),
    .pnt_stall (pnt_stall),
    .pnt       (pnt),
    .rot_valid (rot_valid),
    .rot_stall (rot_stall),
    .rot       (rot)
  );

  ar3d_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .pnt_valid   (pnt_valid),
    .pnt_stall   (pnt_stall),
    .pnt         (pnt),
    .rot_valid   (rot_valid),
    .rot_stall   (rot_stall),
    .rot         (rot),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Coordinates lean on the extremes and on small values, where saturation and
  // rounding near zero show up; the rest is uniform over the full range.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'(16'h7FFF);
      1:       return coord_t'(16'h8000);
      2, 3:    return coord_t'(int'($urandom_range(0, 511)) - 256);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic pnt_t rand_point();
    pnt_t p;
    logic [ANGLE_WIDTH-1:0] near_quad;
    p.mode = ($urandom_range(0, 15) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
    p.in_x = rand_coord();
    p.in_y = rand_coord();
    p.in_z = rand_coord();
    // some angles sit just around a quarter turn boundary
    near_quad = ANGLE_WIDTH'($urandom_range(0, 3) << (ANGLE_WIDTH - 2));
    if ($urandom_range(0, 7) == 0)
      p.turn_angle = near_quad + ANGLE_WIDTH'($urandom_range(0, 8)) - ANGLE_WIDTH'(4);
    else
      p.turn_angle = ANGLE_WIDTH'($urandom);
    return p;
  endfunction

  function automatic pnt_t mk_point(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                                    logic [15:0] z, logic [15:0] ang);
    pnt_t p;
    p.mode       = mode;
    p.in_x       = coord_t'(x);
    p.in_y       = coord_t'(y);
    p.in_z       = coord_t'(z);
    p.turn_angle = ANGLE_WIDTH'(ang);
    return p;
  endfunction

  // Offer one item from a falling edge and hold it until a rising edge takes it.
  // Valid stays high straight into the next item when no gap follows.
  task automatic send_point(input pnt_t p, input int gap);
    @(negedge clk);
    pnt       <= p;
    pnt_valid <= 1'b1;
    @(posedge clk);
    while (pnt_stall) @(posedge clk);
    if (gap > 0) begin
      @(negedge clk);
      pnt_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Take valid down before waiting, so the last item is not offered again.
  task automatic wait_drained();
    @(negedge clk);
    pnt_valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  // Sender stops until every pending result is back, then asks the receiver for
  // a long hold-off and streams items back to back; the pipeline fills up and
  // pnt_stall has to push back on the input.
  task automatic squeeze_pipeline(input int count);
    wait_drained();
    hold_req = 1'b1;
    for (int k = 0; k < count; k++) send_point(rand_point(), 0);
  endtask

  // Receiver: random stall stretches with quiet spells of no stall at all, plus
  // the long hold-off on request, counted here in cycles.
  initial begin : receiver
    int stall_left;
    int hold_left;
    bit quiet;
    int len;
    stall_left = 0;
    hold_left  = 0;
    quiet      = 1'b0;
    rot_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rot_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rot_stall <= 1'b1;
      end else begin
        if ($urandom_range(0, 199) == 0) quiet = !quiet;
        len = quiet ? 0 : idle_length();
        if (len > 0) begin
          stall_left = len - 1;
          rot_stall <= 1'b1;
        end else begin
          rot_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int gap;
    rst       = 1'b1;
    pnt_valid = 1'b0;
    pnt       = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed: every axis and quarter turn, the no-axis selector, saturation at
    // 45 degrees with full-scale pairs, the most negative value turned by a half
    // turn, one-step angles and axis coordinates at the extremes.
    send_point(mk_point(AXIS_X, 16'd100, 16'd200, 16'd300, 16'h0000), 0);
    send_point(mk_point(AXIS_Y, 16'd100, 16'd200, 16'd300, 16'h4000), 0);
    send_point(mk_point(AXIS_Z, 16'd100, 16'd200, 16'd300, 16'h8000), 1);
    send_point(mk_point(AXIS_X, 16'd100, 16'd200, 16'd300, 16'hC000), 0);
    send_point(mk_point(AXIS_NONE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h1234), 0);
    send_point(mk_point(AXIS_Z, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h2000), 2);
    send_point(mk_point(AXIS_Z, 16'h8000, 16'h8000, 16'h7FFF, 16'h2000), 0);
    send_point(mk_point(AXIS_X, 16'h8000, 16'h7FFF, 16'h8000, 16'h2000), 0);
    send_point(mk_point(AXIS_Y, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hE000), 0);
    send_point(mk_point(AXIS_Y, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF), 3);
    send_point(mk_point(AXIS_X, 16'h8000, 16'h8000, 16'h8000, 16'h0001), 0);
    send_point(mk_point(AXIS_Z, 16'h8000, 16'h0000, 16'h1234, 16'h8000), 0);
    send_point(mk_point(AXIS_Y, 16'h0000, 16'h8000, 16'h8000, 16'h4000), 0);
    send_point(mk_point(AXIS_X, 16'h0000, 16'h0000, 16'h0000, 16'h5555), 1);
    send_point(mk_point(AXIS_Z, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h3FFF), 0);
    send_point(mk_point(AXIS_X, 16'h8000, 16'h0100, 16'h0000, 16'h0AAA), 0);
    send_point(mk_point(AXIS_NONE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF), 0);
    send_point(mk_point(AXIS_Y, 16'hFF00, 16'h8000, 16'h0100, 16'h6000), 0);

    squeeze_pipeline(40);

    // Random points; every third block of 128 goes back to back, the sender
    // drains every 250 points and squeezes the pipeline once halfway through.
    for (int k = 0; k < RANDOM_POINTS; k++) begin
      if (k == RANDOM_POINTS / 2) squeeze_pipeline(40);
      if (k % 250 == 249) wait_drained();
      gap = ((k / 128) % 3 == 1) ? 0 : idle_length();
      send_point(rand_point(), gap);
    end

    @(negedge clk);
    pnt_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/ar3d_pkg.sv
hdl/ar3d_cordic_stage.sv
hdl/ar3d_gain.sv
hdl/axis_rotation_3d.sv
test/ar3d_checker.sv
test/tb_axis_rotation_3d.sv
